### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the one-time code generator.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that an expression is never true.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

### sv/totp_pkg.sv
// Types, constants and helper functions of the one-time code generator.
// No dependencies; used by every module of the block.
package totp_pkg;

    typedef logic [159:0] hash_t;
    typedef logic [511:0] block_t;
    typedef logic [31:0]  word_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_KEY_WORD_0 = 3'd0,
        REG_KEY_WORD_1 = 3'd1,
        REG_KEY_WORD_2 = 3'd2,
        REG_KEY_WORD_3 = 3'd3,
        REG_KEY_LENGTH = 3'd4
    } cfg_reg_t;

    // Top-level sequencer
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_STEP  = 7'b0000010,
        ST_DIVC  = 7'b0000100,
        ST_HASH  = 7'b0001000,
        ST_TRUNC = 7'b0010000,
        ST_DIVM  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } seq_state_t;

    // SHA-1 compression engine
    typedef enum logic [2:0] {
        SHA_IDLE  = 3'b001,
        SHA_ROUND = 3'b010,
        SHA_FINAL = 3'b100
    } sha_state_t;

    localparam logic [63:0] STEP_US      = 64'd30000000;
    // seconds / 30 with seconds = us / 10^6 equals us / (30 * 10^6)
    localparam logic [63:0] PERIOD_US    = 64'd30000000;
    localparam logic [63:0] CODE_MOD     = 64'd100000000;
    localparam logic [30:0] CODE_MASK    = 31'h7fffffff;
    localparam logic [3:0]  TRUNC_MASK   = 4'h0f;
    localparam int          SHA_ROUNDS   = 80;
    localparam logic [63:0] INNER_BITS   = 64'd576;
    localparam logic [63:0] OUTER_BITS   = 64'd672;
    localparam logic [7:0]  IPAD         = 8'h36;
    localparam logic [7:0]  OPAD         = 8'h5c;
    localparam logic [7:0]  PAD_MARK     = 8'h80;

    // Constant division by reciprocal: q = ((n >> PRESHIFT) * RECIP) >> RSHIFT.
    // The divisors are 2^7 * 234375 and 2^8 * 390625; the shift after the
    // multiply is wide enough that the rounded-up reciprocal is exact for any
    // 64-bit time and any 31-bit truncated code.
    localparam int          PERIOD_PRESHIFT = 7;
    localparam int          PERIOD_RSHIFT   = 75;
    localparam int          CODE_PRESHIFT   = 8;
    localparam int          CODE_RSHIFT     = 42;
    localparam logic [63:0] PERIOD_RECIP    =
        64'(((128'd1 << PERIOD_RSHIFT) / {64'd0, PERIOD_US >> PERIOD_PRESHIFT}) + 128'd1);
    localparam logic [63:0] CODE_RECIP      =
        64'(((128'd1 << CODE_RSHIFT) / {64'd0, CODE_MOD >> CODE_PRESHIFT}) + 128'd1);

    localparam hash_t SHA_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                32'h10325476, 32'hC3D2E1F0};

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    function automatic word_t rotl(input word_t x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

### sv/totp_sha1.sv
// Iterative SHA-1 compression: one round per cycle, rolling 16-word schedule.
// Depends on totp_pkg.
module totp_sha1
    import totp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  hash_t  h_in,
    input  block_t blk,
    output logic   done,
    output hash_t  h_out
);

    sha_state_t state_reg, state_next;
    logic [6:0] round_reg;
    hash_t      h_in_reg;
    word_t      a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t      w_reg [16];
    logic       done_reg;
    hash_t      h_out_reg;

    word_t f_val, k_val, t_val, w_new;

    // Round function and schedule expansion
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
        t_val = rotl(a_reg, 5) + f_val + e_reg + k_val + w_reg[0];
        w_new = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SHA_IDLE:  if (start) state_next = SHA_ROUND;
            SHA_ROUND: if (round_reg == 7'(SHA_ROUNDS - 1)) state_next = SHA_FINAL;
            SHA_FINAL: state_next = SHA_IDLE;
            default:   state_next = SHA_IDLE;
        endcase
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SHA_IDLE;
            round_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SHA_FINAL);
            if (state_reg == SHA_IDLE)
                round_reg <= '0;
            else if (state_reg == SHA_ROUND)
                round_reg <= round_reg + 7'd1;
        end
    end

    // Datapath: load, run rounds, add chaining value
    always_ff @(posedge clk)
    begin
        if (state_reg == SHA_IDLE && start)
        begin
            h_in_reg <= h_in;
            {a_reg, b_reg, c_reg, d_reg, e_reg} <= h_in;
            for (int j = 0; j < 16; j++)
                w_reg[j] <= blk[511 - 32 * j -: 32];
        end
        else if (state_reg == SHA_ROUND)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= rotl(b_reg, 30);
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int j = 0; j < 15; j++)
                w_reg[j] <= w_reg[j + 1];
            w_reg[15] <= w_new;
        end
        else if (state_reg == SHA_FINAL)
        begin
            h_out_reg <= {h_in_reg[159:128] + a_reg, h_in_reg[127:96] + b_reg,
                          h_in_reg[95:64] + c_reg, h_in_reg[63:32] + d_reg,
                          h_in_reg[31:0] + e_reg};
        end
    end

    assign done  = done_reg;
    assign h_out = h_out_reg;

endmodule

### sv/totp_div.sv
// Constant divider by reciprocal multiplication on one shared 32x32 multiplier,
// four partial products accumulated in turn. Depends on totp_pkg.
module totp_div
    import totp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        code_mode,
    input  logic [63:0] dividend,
    output logic        done,
    output logic [63:0] quotient
);

    logic         busy_reg;
    logic         done_reg;
    logic [1:0]   part_reg;
    logic         mode_reg;
    logic [63:0]  num_reg;
    logic [63:0]  recip_reg;
    logic [127:0] acc_reg;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod;
    logic [127:0] prod_aligned;

    // Pick the limbs of this partial product and align it
    always_comb
    begin
        mul_a = part_reg[1] ? num_reg[63:32] : num_reg[31:0];
        mul_b = part_reg[0] ? recip_reg[63:32] : recip_reg[31:0];
        prod  = {32'd0, mul_a} * {32'd0, mul_b};
        case (part_reg)
            2'd0:    prod_aligned = {64'd0, prod};
            2'd3:    prod_aligned = {prod, 64'd0};
            default: prod_aligned = {32'd0, prod, 32'd0};
        endcase
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            part_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (part_reg == 2'd3);
            if (!busy_reg && start)
            begin
                busy_reg <= 1'b1;
                part_reg <= '0;
            end
            else if (busy_reg)
            begin
                part_reg <= part_reg + 2'd1;
                if (part_reg == 2'd3)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Load operands, then accumulate one partial product per cycle
    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            mode_reg  <= code_mode;
            num_reg   <= code_mode ? (dividend >> CODE_PRESHIFT)
                                   : (dividend >> PERIOD_PRESHIFT);
            recip_reg <= code_mode ? CODE_RECIP : PERIOD_RECIP;
            acc_reg   <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_reg + prod_aligned;
    end

    assign done     = done_reg;
    assign quotient = mode_reg ? 64'(acc_reg >> CODE_RSHIFT) : 64'(acc_reg >> PERIOD_RSHIFT);

endmodule

### sv/totp_window_code_generator_unit.sv
// Top level of the one-time code generator: config registers, sequencer,
// shared SHA-1 engine and divider. Depends on totp_pkg, totp_sha1, totp_div.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | time_us
//  out     | out_valid / out_stall| otp_code, window_offset, last_code
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request yields 2*WINDOW_HALF_WIDTH+1 codes. Each code walks its time
// steps, then runs four SHA-1 compressions and two reciprocal divides
// (step counter, then modulo).
// Reset clears the key registers to zero and returns to idle; in_stall is
// high from acceptance until the last code has been loaded for output.
// A stalled output holds its register; the sequencer waits to load the next.
`include "assert_macros.svh"

module totp_window_code_generator_unit
    import totp_pkg::*;
#(
    parameter int WINDOW_HALF_WIDTH = 2,
    parameter int KEY_BYTES_MAX     = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] time_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [26:0] otp_code,
    output logic [2:0]  window_offset,
    output logic        last_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CNT_W = $clog2(WINDOW_HALF_WIDTH + 2);
    localparam int OFF_W = CNT_W + 1;

    seq_state_t         state_reg;
    logic [63:0]        key_word_reg [4];
    logic [5:0]         key_len_reg;
    logic [63:0]        t0_reg, t_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic [CNT_W-1:0]   step_cnt_reg;
    logic [1:0]         phase_reg;
    logic               sha_go_reg;
    logic [63:0]        ctr_reg;
    hash_t              chain_reg, inner_reg;
    logic               out_valid_reg;
    logic [26:0]        otp_code_reg;
    logic [2:0]         window_offset_reg;
    logic               last_code_reg;

    logic [6:0]         eff_len;
    block_t             key_blk;
    block_t             sha_blk;
    hash_t              sha_h_in;
    logic               sha_done;
    hash_t              sha_h_out;
    logic               div_start, div_done, div_code;
    logic [63:0]        div_dividend, div_quo;
    hash_t              mac_shift;
    logic [30:0]        code31;
    logic [30:0]        code_rem;
    logic signed [OFF_W-1:0] off_inc;
    logic [OFF_W-1:0]   off_abs;
    logic               out_free;
    logic               is_last;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 4; j++)
                key_word_reg[j] <= '0;
            key_len_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_WORD_0: key_word_reg[0] <= cfg_data;
                REG_KEY_WORD_1: key_word_reg[1] <= cfg_data;
                REG_KEY_WORD_2: key_word_reg[2] <= cfg_data;
                REG_KEY_WORD_3: key_word_reg[3] <= cfg_data;
                REG_KEY_LENGTH: key_len_reg     <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Build the zero-padded key block, dropping bytes past the length
    assign eff_len = ({1'b0, key_len_reg} > 7'(KEY_BYTES_MAX)) ? 7'(KEY_BYTES_MAX)
                                                               : {1'b0, key_len_reg};

    always_comb
    begin
        key_blk = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (7'(i) < eff_len)
                key_blk[511 - 8 * i -: 8] = key_word_reg[i / 8][63 - 8 * (i % 8) -: 8];
        end
    end

    // Select message block and chaining value for the current compression
    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                sha_blk  = key_blk ^ {64{IPAD}};
                sha_h_in = SHA_IV;
            end
            2'd1:
            begin
                sha_blk  = {ctr_reg, PAD_MARK, 376'd0, INNER_BITS};
                sha_h_in = chain_reg;
            end
            2'd2:
            begin
                sha_blk  = key_blk ^ {64{OPAD}};
                sha_h_in = SHA_IV;
            end
            default:
            begin
                sha_blk  = {inner_reg, PAD_MARK, 280'd0, OUTER_BITS};
                sha_h_in = chain_reg;
            end
        endcase
    end

    totp_sha1 u_sha1 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sha_go_reg),
        .h_in  (sha_h_in),
        .blk   (sha_blk),
        .done  (sha_done),
        .h_out (sha_h_out)
    );

    // Dynamic truncation of the final MAC
    assign mac_shift = chain_reg >> (8'd128 - {1'b0, chain_reg[3:0] & TRUNC_MASK, 3'b000});
    assign code31    = mac_shift[30:0] & CODE_MASK;

    // Divider serves the step counter first, then the final modulo
    assign div_start    = (state_reg == ST_STEP && step_cnt_reg == '0) ||
                          (state_reg == ST_TRUNC);
    assign div_code     = (state_reg == ST_TRUNC);
    assign div_dividend = div_code ? {33'd0, code31} : t_reg;

    totp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .code_mode (div_code),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quo)
    );

    // A 31-bit value holds at most 21 multiples of 10^8
    assign code_rem = code31 - ({26'd0, div_quo[4:0]} * CODE_MOD[30:0]);

    // Next offset and its step count
    assign off_inc  = off_reg + OFF_W'(1);
    assign off_abs  = off_inc[OFF_W-1] ? OFF_W'(-off_inc) : OFF_W'(off_inc);
    assign out_free = !out_valid_reg || !out_stall;
    assign is_last  = (off_reg == OFF_W'(WINDOW_HALF_WIDTH));

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sha_go_reg    <= 1'b0;
            phase_reg     <= '0;
            step_cnt_reg  <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sha_go_reg <= (state_reg == ST_DIVC && div_done) ||
                          (state_reg == ST_HASH && sha_done && phase_reg != 2'd3);
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        off_reg      <= -OFF_W'(WINDOW_HALF_WIDTH);
                        step_cnt_reg <= CNT_W'(WINDOW_HALF_WIDTH);
                        state_reg    <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    if (step_cnt_reg == '0)
                        state_reg <= ST_DIVC;
                    else
                        step_cnt_reg <= step_cnt_reg - CNT_W'(1);
                end
                ST_DIVC:
                begin
                    if (div_done)
                    begin
                        phase_reg <= '0;
                        state_reg <= ST_HASH;
                    end
                end
                ST_HASH:
                begin
                    if (sha_done)
                    begin
                        if (phase_reg == 2'd3)
                            state_reg <= ST_TRUNC;
                        else
                            phase_reg <= phase_reg + 2'd1;
                    end
                end
                ST_TRUNC:
                    state_reg <= ST_DIVM;
                ST_DIVM:
                    if (div_done)
                        state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        if (is_last)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            off_reg      <= off_inc;
                            step_cnt_reg <= off_abs[CNT_W-1:0];
                            state_reg    <= ST_STEP;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            t0_reg <= time_us;
            t_reg  <= time_us;
        end
        else if (state_reg == ST_STEP && step_cnt_reg != '0)
        begin
            // Move one period, saturating at zero below and at forever above; a time at forever stays there
            if (off_reg[OFF_W-1])
            begin
                if (t_reg != '1)
                    t_reg <= (t_reg <= STEP_US) ? 64'd0 : t_reg - STEP_US;
            end
            else
                t_reg <= (t_reg > ~STEP_US) ? '1 : t_reg + STEP_US;
        end
        else if (state_reg == ST_OUT && out_free)
            t_reg <= t0_reg;

        if (state_reg == ST_DIVC && div_done)
            ctr_reg <= div_quo;

        if (state_reg == ST_HASH && sha_done)
        begin
            if (phase_reg == 2'd1)
                inner_reg <= sha_h_out;
            else
                chain_reg <= sha_h_out;
        end

        if (state_reg == ST_OUT && out_free)
        begin
            otp_code_reg      <= code_rem[26:0];
            window_offset_reg <= 3'(off_reg);
            last_code_reg     <= is_last;
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign otp_code      = otp_code_reg;
    assign window_offset = window_offset_reg;
    assign last_code     = last_code_reg;

    `ASSERT_NEXT(a_start_offset, in_valid && !in_stall,
        off_reg == -OFF_W'(WINDOW_HALF_WIDTH), "run does not start at lowest offset")
    `ASSERT_IMPLIES(a_code_range, out_valid, otp_code < 27'd100000000,
        "code out of eight-digit range")
    `ASSERT_NEVER(a_sha_div_overlap, sha_go_reg && div_start,
        "hash and divider launched together")
    `ASSERT_IMPLIES(a_last_offset, out_valid && last_code,
        window_offset == 3'(WINDOW_HALF_WIDTH), "last code not at top offset")

endmodule

### tb/totp_window_code_generator_unit_test.sv
// Testbench of totp_window_code_generator_unit: HMAC-SHA1 TOTP codes for five windows.
// Depends on totp_pkg and the RTL; a scoreboard class predicts and checks each code.
`timescale 1ns / 1ps

module totp_window_code_generator_unit_test;
    import totp_pkg::*;

    localparam int          WINDOW_HALF    = 2;
    localparam int          KEY_BYTES_TOP  = 32;
    localparam int          IDLE_PERCENT   = 36;
    localparam int          HOLD_CYCLES    = 3000;
    localparam int          STALL_LIMIT    = 20000;
    localparam int          DRAIN_CYCLES   = 60;
    localparam int          REPORT_LIMIT   = 10;
    localparam logic [2:0]  REG_UNUSED_LOW = 3'd5;
    localparam logic [63:0] FOREVER_US     = 64'hffff_ffff_ffff_ffff;

    // Predicts the codes of each accepted request and checks the results
    class totp_code_scoreboard;
        typedef struct packed {
            logic [26:0] code;
            logic [2:0]  offset;
            logic        last;
        } totp_code_t;

        logic [63:0] key_word[4];
        logic [5:0]  key_len;
        totp_code_t  expected_codes[$];
        int          mismatches;
        int          checked;
        int          requests;

        function new();
            foreach (key_word[i])
                key_word[i] = '0;
            key_len    = '0;
            mismatches = 0;
            checked    = 0;
            requests   = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [63:0] data);
            case (idx)
                REG_KEY_WORD_0: key_word[0] = data;
                REG_KEY_WORD_1: key_word[1] = data;
                REG_KEY_WORD_2: key_word[2] = data;
                REG_KEY_WORD_3: key_word[3] = data;
                REG_KEY_LENGTH: key_len = data[5:0];
                default: ;
            endcase
        endfunction

        static function logic [159:0] sha1_compress(logic [159:0] h, logic [511:0] blk);
            logic [31:0] w[80];
            logic [31:0] a, b, c, d, e, f, k, t, x;
            for (int i = 0; i < 16; i++)
                w[i] = blk[511 - 32 * i -: 32];
            for (int i = 16; i < 80; i++)
            begin
                x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
                w[i] = {x[30:0], x[31]};
            end
            {a, b, c, d, e} = h;
            for (int i = 0; i < 80; i++)
            begin
                if (i < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = K0;
                end
                else if (i < 40)
                begin
                    f = b ^ c ^ d;
                    k = K1;
                end
                else if (i < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K2;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = K3;
                end
                t = {a[26:0], a[31:27]} + f + e + k + w[i];
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
        endfunction

        static function logic [26:0] window_code(logic [63:0] t_us, logic [511:0] key);
            logic [63:0]  step_count;
            logic [159:0] inner, mac;
            logic [31:0]  word;
            int           pick;
            step_count = t_us / PERIOD_US;
            inner = sha1_compress(SHA_IV, key ^ {64{IPAD}});
            inner = sha1_compress(inner, {step_count, PAD_MARK, 376'b0, INNER_BITS});
            mac = sha1_compress(SHA_IV, key ^ {64{OPAD}});
            mac = sha1_compress(mac, {inner, PAD_MARK, 280'b0, OUTER_BITS});
            pick = mac[3:0];
            word = mac[159 - 8 * pick -: 32] & {1'b0, CODE_MASK};
            return 27'(word % CODE_MOD[31:0]);
        endfunction

        // Queue the five window codes of one accepted request
        function void note_request(logic [63:0] t0);
            logic [511:0] key;
            logic [63:0]  t;
            totp_code_t   item;
            int           len;
            len = (key_len > KEY_BYTES_TOP) ? KEY_BYTES_TOP : key_len;
            key = {key_word[0], key_word[1], key_word[2], key_word[3], 256'b0};
            key = key & ~({512{1'b1}} >> (len * 8));
            for (int off = -WINDOW_HALF; off <= WINDOW_HALF; off++)
            begin
                t = t0;
                for (int s = 0; s < (off < 0 ? -off : off); s++)
                begin
                    if (off < 0)
                    begin
                        if (t != FOREVER_US)
                            t = (t <= STEP_US) ? 64'd0 : t - STEP_US;
                    end
                    else
                        t = (t > FOREVER_US - STEP_US) ? FOREVER_US : t + STEP_US;
                end
                item.code   = window_code(t, key);
                item.offset = 3'(off);
                item.last   = (off == WINDOW_HALF);
                expected_codes.push_back(item);
            end
            requests++;
        endfunction

        function void check_code(logic [26:0] code, logic [2:0] offset, logic last);
            totp_code_t want;
            checked++;
            if (expected_codes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected code %0d offset %0d last %0b", code, offset, last);
                return;
            end
            want = expected_codes.pop_front();
            if (code !== want.code || offset !== want.offset || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("code mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                             want.code, want.offset, want.last, code, offset, last);
            end
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] time_us;
    logic        out_valid;
    logic        out_stall;
    logic [26:0] otp_code;
    logic [2:0]  window_offset;
    logic        last_code;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    totp_code_scoreboard codes_sb;
    bit calm;
    int hold_ask;
    int hold_done;
    int watchdog_count;
    int key_settings;

    totp_window_code_generator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .time_us       (time_us),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .otp_code      (otp_code),
        .window_offset (window_offset),
        .last_code     (last_code),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Drain codes; stall at random, or hold off for a long stretch on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                codes_sb.check_code(otp_code, window_offset, last_code);
            if (hold_ask != hold_done)
            begin
                hold_done = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // End the run when no channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            watchdog_count <= 0;
        else if (watchdog_count >= STALL_LIMIT)
        begin
            $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("totp_window_code_generator_unit_test: errors");
            $finish;
        end
        else
            watchdog_count <= watchdog_count + 1;
    end

    // Write one register; the caller lowers cfg_valid after the batch
    task automatic write_register(logic [2:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        codes_sb.set_register(idx, data);
    endtask

    task automatic program_key(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                               logic [63:0] w3, logic [5:0] len);
        write_register(REG_KEY_WORD_0, w0);
        write_register(REG_KEY_WORD_1, w1);
        write_register(REG_KEY_WORD_2, w2);
        write_register(REG_KEY_WORD_3, w3);
        write_register(REG_KEY_LENGTH, len);
        // writes to unused indexes must leave the key alone
        write_register(3'($urandom_range(REG_UNUSED_LOW, 7)), {$urandom, $urandom});
        cfg_valid <= 1'b0;
        key_settings++;
    endtask

    // Offer one request after an optional idle gap; hold it until accepted
    task automatic send_request(logic [63:0] t);
        int gap;
        gap = (!calm && $urandom_range(99) < IDLE_PERCENT) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        time_us  <= t;
        do
            @(posedge clk);
        while (in_stall);
        codes_sb.note_request(t);
    endtask

    task automatic drain_codes();
        in_valid <= 1'b0;
        while (codes_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] random_time();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 200000000));
            2: return FOREVER_US - 64'($urandom_range(0, 100000000));
            default: return 64'd1_700_000_000_000_000 + 64'($urandom);
        endcase
    endfunction

    initial
    begin
        codes_sb     = new();
        calm         = 1'b0;
        hold_ask     = 0;
        key_settings = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        time_us      <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty key after reset, time extremes and saturation edges
        send_request(64'd0);
        send_request(64'd1);
        send_request(STEP_US);
        send_request(STEP_US + 64'd1);
        send_request(2 * STEP_US);
        send_request(FOREVER_US);
        send_request(FOREVER_US - 64'd1);
        send_request(FOREVER_US - STEP_US);
        drain_codes();

        // 20-byte ASCII key with junk in the unused bytes; long output hold-off
        program_key(64'h3132333435363738, 64'h3930313233343536, 64'h37383930deadbeef,
                    64'hffffffffffffffff, 6'd20);
        send_request(64'd59_000_000);
        hold_ask++;
        send_request(64'd1_111_111_109_000_000);
        send_request(64'd1_234_567_890_000_000);
        send_request(64'd20_000_000_000_000_000);
        drain_codes();

        // full key, then oversized lengths that clamp to the full key
        program_key(FOREVER_US, FOREVER_US, FOREVER_US, FOREVER_US, 6'd32);
        send_request(64'd0);
        send_request(FOREVER_US);
        drain_codes();
        program_key(64'h0123456789abcdef, 64'hfedcba9876543210, 64'h5555aaaa5555aaaa,
                    64'haaaa5555aaaa5555, 6'd63);
        send_request(64'd59_000_000);
        drain_codes();
        program_key(64'h0123456789abcdef, 64'hfedcba9876543210, 64'h5555aaaa5555aaaa,
                    64'haaaa5555aaaa5555, 6'd33);
        send_request(64'd59_000_000);
        drain_codes();

        // random keys and times; one phase runs with no idling at all
        for (int phase = 0; phase < 8; phase++)
        begin
            calm = (phase == 3);
            program_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom},
                        6'((phase == 0) ? 0 : (phase == 1) ? 63 : $urandom_range(0, 63)));
            for (int n = 0; n < 23; n++)
                send_request(random_time());
            drain_codes();
        end
        calm = 1'b0;

        $display("covered %0d requests, %0d codes checked, %0d key settings",
                 codes_sb.requests, codes_sb.checked, key_settings);
        if (codes_sb.mismatches == 0 && codes_sb.pending() == 0)
            $display("totp_window_code_generator_unit_test: clean");
        else
        begin
            $display("%0d mismatches", codes_sb.mismatches);
            $display("totp_window_code_generator_unit_test: errors");
        end
        $finish;
    end

endmodule
